// ----- hw/rtl/swar_pkg.sv -----
`default_nettype none
package swar_pkg;

  localparam int WGT_W   = 16;
  localparam int BONE_W  = 8;
  localparam int SLOTS   = 4;
  localparam int SLOT_W  = 2;
  localparam int NUM_W   = 31;
  localparam int DEN_W   = 18;
  localparam int QUO_W   = 17;

  localparam logic [16:0] ONE_Q15       = 17'd32768;
  localparam logic [17:0] DIV_FLOOR_Q15 = 18'd33;

  typedef struct packed {
    logic [BONE_W-1:0] bone_slot0;
    logic [BONE_W-1:0] bone_slot1;
    logic [BONE_W-1:0] bone_slot2;
    logic [BONE_W-1:0] bone_slot3;
    logic [WGT_W-1:0]  weight_slot0;
    logic [WGT_W-1:0]  weight_slot1;
    logic [WGT_W-1:0]  weight_slot2;
    logic [WGT_W-1:0]  weight_slot3;
    logic [WGT_W-1:0]  increment;
  } swar_in_t;

  typedef struct packed {
    logic [BONE_W-1:0] new_bone0;
    logic [BONE_W-1:0] new_bone1;
    logic [BONE_W-1:0] new_bone2;
    logic [BONE_W-1:0] new_bone3;
    logic [WGT_W-1:0]  new_weight0;
    logic [WGT_W-1:0]  new_weight1;
    logic [WGT_W-1:0]  new_weight2;
    logic [WGT_W-1:0]  new_weight3;
    logic              zero_total;
  } swar_out_t;

  // Side data that rides along the first divider.
  typedef struct packed {
    logic [SLOTS-1:0][BONE_W-1:0] bone;
    logic [SLOT_W-1:0]            slot;
    logic [WGT_W-1:0]             neww;
  } swar_sb1_t;

  // Side data that rides along the second divider.
  typedef struct packed {
    logic [SLOTS-1:0][BONE_W-1:0] bone;
    logic                         zero;
  } swar_sb2_t;

  localparam int SB1_W = $bits(swar_sb1_t);
  localparam int SB2_W = $bits(swar_sb2_t);

  function automatic logic [WGT_W-1:0] sat_q15(input logic [16:0] v);
    logic [WGT_W-1:0] r;
    if (v > ONE_Q15) begin
      r = WGT_W'(ONE_Q15);
    end else begin
      r = v[WGT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/swar_stream_if.sv -----
`default_nettype none
interface swar_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/swar_front.sv -----
`default_nettype none
module swar_front #(
  parameter int BONE_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [swar_pkg::BONE_W-1:0] target_bone,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire swar_pkg::swar_in_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [swar_pkg::SLOTS-1:0][swar_pkg::NUM_W-1:0] out_num,
  output logic [swar_pkg::DEN_W-1:0]       out_den,
  output logic [swar_pkg::SB1_W-1:0]       out_sb
);
  import swar_pkg::*;

  localparam int CMP_BITS = (BONE_BITS < BONE_W) ? BONE_BITS : BONE_W;

  // Stage A: saturation, slot choice, new weight and divisor.
  logic                         a_valid_r;
  logic [SLOTS-1:0][WGT_W-1:0]  a_w_r;
  logic [DEN_W-1:0]             a_div_r;
  swar_sb1_t                    a_sb_r;
  // Stage B: scaled numerators.
  logic                         b_valid_r;
  logic [SLOTS-1:0][NUM_W-1:0]  b_num_r;
  logic [DEN_W-1:0]             b_div_r;
  swar_sb1_t                    b_sb_r;

  logic a_en, b_en;
  assign b_en     = !b_valid_r || out_ready;
  assign a_en     = !a_valid_r || b_en;
  assign in_ready = a_en;

  logic [SLOTS-1:0][BONE_W-1:0] bone_in;
  logic [SLOTS-1:0][WGT_W-1:0]  w_sat;
  logic [WGT_W-1:0]             inc_sat;
  logic [SLOTS-1:0]             match;
  logic [SLOT_W-1:0]            hit_slot, min_slot, slot_nxt;
  logic [WGT_W-1:0]             oldw, neww_nxt;
  logic [DEN_W-1:0]             rest, div_nxt;
  swar_sb1_t                    a_sb_nxt;

  always_comb begin
    bone_in = {in_data.bone_slot3, in_data.bone_slot2,
               in_data.bone_slot1, in_data.bone_slot0};
    w_sat[0] = sat_q15({1'b0, in_data.weight_slot0});
    w_sat[1] = sat_q15({1'b0, in_data.weight_slot1});
    w_sat[2] = sat_q15({1'b0, in_data.weight_slot2});
    w_sat[3] = sat_q15({1'b0, in_data.weight_slot3});
    inc_sat  = sat_q15({1'b0, in_data.increment});
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = (bone_in[i][CMP_BITS-1:0] == target_bone[CMP_BITS-1:0]);
    end
    hit_slot = SLOT_W'(3);
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = SLOT_W'(i);
      end
    end
    oldw     = (|match) ? w_sat[hit_slot] : '0;
    neww_nxt = sat_q15({1'b0, oldw} + {1'b0, inc_sat});
    min_slot = '0;
    for (int i = 1; i < SLOTS; i++) begin
      if (w_sat[i] < w_sat[min_slot]) begin
        min_slot = SLOT_W'(i);
      end
    end
    slot_nxt = (|match) ? hit_slot : min_slot;
    a_sb_nxt.bone = bone_in;
    if (!(|match)) begin
      a_sb_nxt.bone[slot_nxt] = target_bone;
    end
    a_sb_nxt.slot = slot_nxt;
    a_sb_nxt.neww = neww_nxt;
    rest = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (SLOT_W'(i) != slot_nxt) begin
        rest = rest + DEN_W'(w_sat[i]);
      end
    end
    div_nxt = (rest > DIV_FLOOR_Q15) ? rest : DIV_FLOOR_Q15;
  end

  logic [16:0]                 remw;
  logic [SLOTS-1:0][NUM_W-1:0] b_num_nxt;

  always_comb begin
    remw = ONE_Q15 - {1'b0, a_sb_r.neww};
    for (int i = 0; i < SLOTS; i++) begin
      b_num_nxt[i] = NUM_W'({a_w_r[i], 17'd0} >> 17) * NUM_W'(remw)
                     + NUM_W'(a_div_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_r <= in_valid;
      end
      if (b_en) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_w_r   <= w_sat;
      a_div_r <= div_nxt;
      a_sb_r  <= a_sb_nxt;
    end
    if (b_en) begin
      b_num_r <= b_num_nxt;
      b_div_r <= a_div_r;
      b_sb_r  <= a_sb_r;
    end
  end

  assign out_valid = b_valid_r;
  assign out_num   = b_num_r;
  assign out_den   = b_div_r;
  assign out_sb    = b_sb_r;

endmodule
`default_nettype wire

// ----- hw/rtl/swar_div.sv -----
`default_nettype none
module swar_div #(
  parameter int LANES = 4,
  parameter int NUM_W = 31,
  parameter int DEN_W = 18,
  parameter int QUO_W = 17,
  parameter int SB_W  = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [LANES-1:0][NUM_W-1:0]      in_num,
  input  wire logic [DEN_W-1:0]                 in_den,
  input  wire logic [SB_W-1:0]                  in_sb,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [LANES-1:0][QUO_W-1:0]           out_quo,
  output logic [SB_W-1:0]                       out_sb
);

  // One quotient bit per stage, most significant first.
  logic [QUO_W-1:0]                          valid_r;
  logic [QUO_W:0]                            en;
  logic [QUO_W-1:0][LANES-1:0][NUM_W-1:0]    rem_r;
  logic [QUO_W-1:0][LANES-1:0][QUO_W-1:0]    quo_r;
  logic [QUO_W-1:0][DEN_W-1:0]               den_r;
  logic [QUO_W-1:0][SB_W-1:0]                sb_r;

  assign en[QUO_W] = out_ready;
  assign in_ready  = en[0];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int K = QUO_W - 1 - j;
    logic                          v_in;
    logic [LANES-1:0][NUM_W-1:0]   rem_in, rem_nxt;
    logic [LANES-1:0][QUO_W-1:0]   quo_in, quo_nxt;
    logic [DEN_W-1:0]              den_in;
    logic [SB_W-1:0]               sb_in;

    assign en[j] = !valid_r[j] || en[j+1];

    if (j == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = in_num;
      assign quo_in = '0;
      assign den_in = in_den;
      assign sb_in  = in_sb;
    end else begin : g_next
      assign v_in   = valid_r[j-1];
      assign rem_in = rem_r[j-1];
      assign quo_in = quo_r[j-1];
      assign den_in = den_r[j-1];
      assign sb_in  = sb_r[j-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rem_nxt[l] = rem_in[l];
        quo_nxt[l] = quo_in[l];
        if ((rem_in[l] >> K) >= NUM_W'(den_in)) begin
          rem_nxt[l]    = rem_in[l] - (NUM_W'(den_in) << K);
          quo_nxt[l][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else if (en[j]) begin
        valid_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= rem_nxt;
        quo_r[j] <= quo_nxt;
        den_r[j] <= den_in;
        sb_r[j]  <= sb_in;
      end
    end
  end

  assign out_valid = valid_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];
  assign out_sb    = sb_r[QUO_W-1];

endmodule
`default_nettype wire

// ----- hw/rtl/swar_mid.sv -----
`default_nettype none
module swar_mid (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         in_valid,
  output logic                                              in_ready,
  input  wire logic [swar_pkg::SLOTS-1:0][swar_pkg::QUO_W-1:0] in_quo,
  input  wire swar_pkg::swar_sb1_t                          in_sb,
  output logic                                              out_valid,
  input  wire logic                                         out_ready,
  output logic [swar_pkg::SLOTS-1:0][swar_pkg::NUM_W-1:0]   out_num,
  output logic [swar_pkg::DEN_W-1:0]                        out_den,
  output logic [swar_pkg::SB2_W-1:0]                        out_sb
);
  import swar_pkg::*;

  logic                        valid_r;
  logic [SLOTS-1:0][NUM_W-1:0] num_r;
  logic [DEN_W-1:0]            den_r;
  swar_sb2_t                   sb_r;

  logic                        en;
  logic [SLOTS-1:0][WGT_W-1:0] w;
  logic [DEN_W-1:0]            total;
  logic [SLOTS-1:0][NUM_W-1:0] num_nxt;
  swar_sb2_t                   sb_nxt;

  assign en       = !valid_r || out_ready;
  assign in_ready = en;

  // The target slot keeps its new weight; the others take the scaled values.
  always_comb begin
    total = '0;
    for (int i = 0; i < SLOTS; i++) begin
      w[i]  = (SLOT_W'(i) == in_sb.slot) ? in_sb.neww : in_quo[i][WGT_W-1:0];
      total = total + DEN_W'(w[i]);
    end
    for (int i = 0; i < SLOTS; i++) begin
      num_nxt[i] = (NUM_W'(w[i]) << 15) + NUM_W'(total >> 1);
    end
    sb_nxt.bone = in_sb.bone;
    sb_nxt.zero = (total == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      den_r <= total;
      sb_r  <= sb_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_num   = num_r;
  assign out_den   = den_r;
  assign out_sb    = sb_r;

endmodule
`default_nettype wire

// ----- hw/rtl/skin_weight_add_renormalize_core.sv -----
`default_nettype none
// Skin weight brush update for one vertex with four bone influences.
// The input stream carries one vertex per beat: four bone indices, four
// Q1.15 weights and the brush increment. The output stream returns one beat
// per input beat with the updated bone indices, the renormalized weights and
// a flag that marks a zero weight total. Both streams use valid/ready.
// The brush target bone is set through cfg_we/cfg_data while the block idles;
// the user must keep to this, the block does not enforce it. The pipeline
// takes a new beat every cycle while the receiver does not stall. A beat
// passes two front stages, a 17-stage divider that scales the other weights,
// one summing stage, a second 17-stage divider for the final normalization and the output register.
// Each divider resolves one quotient bit per stage for all four lanes.
// When the receiver stalls, stages fill up one by one; bubbles are squeezed
// out and the input keeps taking beats until every stage holds data. No beat
// is lost or repeated.
// A synchronous reset clears all valid bits and sets the target bone to 0.
module skin_weight_add_renormalize_core #(
  parameter int BONE_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [swar_pkg::BONE_W-1:0] cfg_data,
  swar_stream_if.sink                      in_stream,
  swar_stream_if.source                    out_stream
);
  import swar_pkg::*;

  logic [BONE_W-1:0] target_bone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_bone_r <= '0;
    end else if (cfg_we) begin
      target_bone_r <= cfg_data;
    end
  end

  // Front end: slot choice, new weight, scaled numerators.
  logic                        fr_valid, fr_ready;
  logic [SLOTS-1:0][NUM_W-1:0] fr_num;
  logic [DEN_W-1:0]            fr_den;
  logic [SB1_W-1:0]            fr_sb;

  swar_front #(
    .BONE_BITS (BONE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .target_bone (target_bone_r),
    .in_valid    (in_stream.valid),
    .in_ready    (in_stream.ready),
    .in_data     (in_stream.data),
    .out_valid   (fr_valid),
    .out_ready   (fr_ready),
    .out_num     (fr_num),
    .out_den     (fr_den),
    .out_sb      (fr_sb)
  );

  // First divider: rescale the other three weights.
  logic                        d1_valid, d1_ready;
  logic [SLOTS-1:0][QUO_W-1:0] d1_quo;
  logic [SB1_W-1:0]            d1_sb;

  swar_div #(
    .LANES (SLOTS),
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (QUO_W),
    .SB_W  (SB1_W)
  ) u_div_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_num    (fr_num),
    .in_den    (fr_den),
    .in_sb     (fr_sb),
    .out_valid (d1_valid),
    .out_ready (d1_ready),
    .out_quo   (d1_quo),
    .out_sb    (d1_sb)
  );

  // Weight total and normalization numerators.
  logic                        md_valid, md_ready;
  logic [SLOTS-1:0][NUM_W-1:0] md_num;
  logic [DEN_W-1:0]            md_den;
  logic [SB2_W-1:0]            md_sb;

  swar_mid u_mid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d1_valid),
    .in_ready  (d1_ready),
    .in_quo    (d1_quo),
    .in_sb     (swar_sb1_t'(d1_sb)),
    .out_valid (md_valid),
    .out_ready (md_ready),
    .out_num   (md_num),
    .out_den   (md_den),
    .out_sb    (md_sb)
  );

  // Second divider: divide every weight by the total.
  logic                        d2_valid, d2_ready;
  logic [SLOTS-1:0][QUO_W-1:0] d2_quo;
  logic [SB2_W-1:0]            d2_sb;

  swar_div #(
    .LANES (SLOTS),
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (QUO_W),
    .SB_W  (SB2_W)
  ) u_div_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (md_valid),
    .in_ready  (md_ready),
    .in_num    (md_num),
    .in_den    (md_den),
    .in_sb     (md_sb),
    .out_valid (d2_valid),
    .out_ready (d2_ready),
    .out_quo   (d2_quo),
    .out_sb    (d2_sb)
  );

  // Output register. A zero total forces all weights to zero, since the
  // divider result is meaningless with a zero divisor.
  logic      out_valid_r;
  swar_out_t out_data_r, out_data_nxt;
  swar_sb2_t tail_sb;
  logic      out_en;

  assign tail_sb  = swar_sb2_t'(d2_sb);
  assign out_en   = !out_valid_r || out_stream.ready;
  assign d2_ready = out_en;

  always_comb begin
    out_data_nxt.new_bone0   = tail_sb.bone[0];
    out_data_nxt.new_bone1   = tail_sb.bone[1];
    out_data_nxt.new_bone2   = tail_sb.bone[2];
    out_data_nxt.new_bone3   = tail_sb.bone[3];
    out_data_nxt.new_weight0 = tail_sb.zero ? '0 : d2_quo[0][WGT_W-1:0];
    out_data_nxt.new_weight1 = tail_sb.zero ? '0 : d2_quo[1][WGT_W-1:0];
    out_data_nxt.new_weight2 = tail_sb.zero ? '0 : d2_quo[2][WGT_W-1:0];
    out_data_nxt.new_weight3 = tail_sb.zero ? '0 : d2_quo[3][WGT_W-1:0];
    out_data_nxt.zero_total  = tail_sb.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_stream.valid = out_valid_r;
  assign out_stream.data  = out_data_r;

endmodule
`default_nettype wire
